// ===== sv/ttint_pkg.sv =====
// shared types and constants for the thermistor table interpolator
`default_nettype none
package ttint_pkg;

    localparam int ENTRY_W   = 18;
    localparam int SAMPLE_W  = 12;
    localparam int TEMP_W    = 20;
    localparam int DIV_NUM_W = 31;
    localparam int DIV_DEN_W = 18;
    localparam int CFG_ADDR_W = 5;

    localparam logic       REQ_LOAD    = 1'b0;
    localparam logic       REQ_CONVERT = 1'b1;

    localparam logic [1:0] REGION_INTERP      = 2'd0;
    localparam logic [1:0] REGION_CLAMP_FIRST = 2'd1;
    localparam logic [1:0] REGION_CLAMP_LAST  = 2'd2;
    localparam logic [1:0] REGION_PASS        = 2'd3;

    localparam logic [2:0] CFG_TABLE_ENABLE = 3'd0;
    localparam logic [2:0] CFG_RES_MODE     = 3'd1;
    localparam logic [2:0] CFG_TABLE_LENGTH = 3'd2;
    localparam logic [2:0] CFG_FIRST_DEG    = 3'd3;
    localparam logic [2:0] CFG_LAST_DEG     = 3'd4;
    localparam logic [2:0] CFG_OFFSET       = 3'd5;

    localparam logic [SAMPLE_W-1:0] RES_CLAMP_ADC = 12'd2770;
    localparam logic [ENTRY_W-1:0]  RES_CLAMP_VAL = 18'd221924;
    localparam logic [26:0]         RES_VREF      = 27'd25000;
    localparam logic [14:0]         RES_VREF_15   = 15'd25000;
    localparam logic [30:0]         RES_PULLUP    = 31'd100000;
    localparam logic [30:0]         MILLI_U       = 31'd1000;
    localparam logic signed [31:0]  MILLI_S       = 32'sd1000;
    localparam logic signed [31:0]  OUT_MIN       = -32'sd400000;
    localparam logic signed [31:0]  OUT_MAX       = 32'sd500000;

    typedef struct packed {
        logic                req_type;
        logic [5:0]          entry_index;
        logic [ENTRY_W-1:0]  entry_value;
        logic [SAMPLE_W-1:0] sample;
    } req_item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_milli;
        logic [1:0]               region;
    } rsp_item_t;

endpackage
`default_nettype wire

// ===== sv/ttint_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module ttint_div (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire [ttint_pkg::DIV_NUM_W-1:0] num,
    input  wire [ttint_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [ttint_pkg::DIV_NUM_W-1:0] quo
);
    import ttint_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    always_comb
    begin
        rem_sh  = {rem_reg[DIV_DEN_W-1:0], q_reg[DIV_NUM_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub : rem_sh;
            q_reg   <= {q_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
`default_nettype wire

// ===== sv/thermistor_table_interpolator_core.sv =====
// thermistor table interpolator: top level with config port, table and sequencer
//
// usage:
//   req channel (req_valid/req_ready/req) carries load and convert transactions.
//   a load transaction writes one table entry in the cycle it is accepted and
//   gives no response; an index at or beyond TABLE_DEPTH is dropped.
//   a convert transaction gives one rsp transaction (rsp_valid/rsp_ready/rsp).
//   a passthrough convert goes straight to the output register; a table
//   lookup scans the table, then clamps or interpolates with a division;
//   resistance mode first turns samples up to the clamp into a resistance
//   by a division. the table is read one entry per cycle and both divisions
//   run through one serial divider at one quotient bit per cycle.
//   req_ready is high only while the sequencer is idle; one convert is in
//   flight at a time, and loads go every cycle while the sequencer is idle.
//   a finished response waits in the output register, and the next request
//   may be accepted meanwhile; it completes once the receiver has taken the
//   previous response.
//   reset clears the sequencer, the output register and the config registers
//   (table_length resets to 2); table entries are undefined until loaded.
//   config registers (apb, 4*index) must be written only while idle; unchecked.
`default_nettype none
module thermistor_table_interpolator_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [4:0]             paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire                   req_valid,
    output logic                  req_ready,
    input  wire ttint_pkg::req_item_t req,
    output logic                  rsp_valid,
    input  wire                   rsp_ready,
    output ttint_pkg::rsp_item_t  rsp
);
    import ttint_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int N_W   = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RES_V,
        S_RES_N,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SCAN_GO,
        S_SCAN,
        S_INTERP,
        S_MUL,
        S_OUT
    } state_t;

    // config registers
    logic                 table_enable_reg;
    logic                 res_mode_reg;
    logic [6:0]           table_length_reg;
    logic signed [8:0]    first_deg_reg;
    logic signed [8:0]    last_deg_reg;
    logic signed [18:0]   offset_reg;

    // sequencer and datapath registers
    state_t               state_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [14:0]          volt_reg;
    logic [ENTRY_W-1:0]   x_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [ENTRY_W-1:0]   prev_reg;
    logic [ENTRY_W-1:0]   hi_reg;
    logic [ENTRY_W-1:0]   lo_reg;
    logic [ENTRY_W-1:0]   diff_reg;
    logic [ENTRY_W-1:0]   den_reg;
    logic signed [11:0]   deg_reg;
    logic signed [31:0]   acc_reg;
    logic [1:0]           region_reg;
    logic                 res_phase_reg;
    logic [DIV_NUM_W-1:0] div_num_reg;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_reg;

    // table memory
    logic [ENTRY_W-1:0]   mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]   mem_q;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic                 wr_en;
    logic [31:0]          idx_ext;

    logic                 cfg_wr;
    logic [2:0]           cfg_idx;
    logic                 req_fire;
    logic                 falling;
    logic                 hit;
    logic                 last_entry;
    logic [N_W-1:0]       n_eff;
    logic [26:0]          vprod;
    logic signed [11:0]   cnt_s;
    logic signed [31:0]   sum;
    logic signed [31:0]   sat;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_wr    = psel && penable && pwrite;
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign div_start = (state_reg == S_DIV_GO);

    always_comb
    begin
        case (cfg_idx)
            CFG_TABLE_ENABLE: prdata = {31'd0, table_enable_reg};
            CFG_RES_MODE:     prdata = {31'd0, res_mode_reg};
            CFG_TABLE_LENGTH: prdata = {25'd0, table_length_reg};
            CFG_FIRST_DEG:    prdata = 32'(first_deg_reg);
            CFG_LAST_DEG:     prdata = 32'(last_deg_reg);
            CFG_OFFSET:       prdata = 32'(offset_reg);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_enable_reg <= 1'b0;
            res_mode_reg     <= 1'b0;
            table_length_reg <= 7'd2;
            first_deg_reg    <= '0;
            last_deg_reg     <= '0;
            offset_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_TABLE_ENABLE: table_enable_reg <= pwdata[0];
                CFG_RES_MODE:     res_mode_reg     <= pwdata[0];
                CFG_TABLE_LENGTH: table_length_reg <= pwdata[6:0];
                CFG_FIRST_DEG:    first_deg_reg    <= $signed(pwdata[8:0]);
                CFG_LAST_DEG:     last_deg_reg     <= $signed(pwdata[8:0]);
                CFG_OFFSET:       offset_reg       <= $signed(pwdata[18:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        idx_ext = 32'(req.entry_index);
        wr_addr = idx_ext[IDX_W-1:0];
        wr_en   = req_fire && (req.req_type == REQ_LOAD) && (idx_ext < 32'(TABLE_DEPTH));
        rd_addr = (state_reg == S_SCAN) ? cnt_reg + IDX_W'(1) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.entry_value;
        end
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        if (32'(table_length_reg) < 32'd2)
        begin
            n_eff = N_W'(2);
        end
        else if (32'(table_length_reg) > 32'(TABLE_DEPTH))
        begin
            n_eff = N_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = N_W'(table_length_reg);
        end
        falling    = first_deg_reg > last_deg_reg;
        hit        = falling ? (x_reg <= mem_q) : (x_reg >= mem_q);
        last_entry = (32'(cnt_reg) + 32'd1) == 32'(n_eff);
        vprod      = 27'(sample_reg) * RES_VREF;
        cnt_s      = 12'($signed({1'b0, cnt_reg}));
        sum        = acc_reg + 32'(offset_reg);
        if (sum < OUT_MIN)
        begin
            sat = OUT_MIN;
        end
        else if (sum > OUT_MAX)
        begin
            sat = OUT_MAX;
        end
        else
        begin
            sat = sum;
        end
    end

    ttint_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            sample_reg    <= '0;
            volt_reg      <= '0;
            x_reg         <= '0;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            diff_reg      <= '0;
            den_reg       <= '0;
            deg_reg       <= '0;
            acc_reg       <= '0;
            region_reg    <= REGION_INTERP;
            res_phase_reg <= 1'b0;
            div_num_reg   <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && (state_reg != S_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire && (req.req_type == REQ_CONVERT))
                    begin
                        sample_reg <= req.sample;
                        if (!table_enable_reg)
                        begin
                            acc_reg    <= $signed(32'(req.sample));
                            region_reg <= REGION_PASS;
                            state_reg  <= S_OUT;
                        end
                        else if (res_mode_reg && (req.sample > RES_CLAMP_ADC))
                        begin
                            x_reg     <= RES_CLAMP_VAL;
                            state_reg <= S_SCAN_GO;
                        end
                        else if (res_mode_reg)
                        begin
                            state_reg <= S_RES_V;
                        end
                        else
                        begin
                            x_reg     <= ENTRY_W'(req.sample);
                            state_reg <= S_SCAN_GO;
                        end
                    end
                end
                S_RES_V:
                begin
                    volt_reg  <= vprod[26:12];
                    state_reg <= S_RES_N;
                end
                S_RES_N:
                begin
                    div_num_reg   <= 31'(volt_reg) * RES_PULLUP;
                    den_reg       <= ENTRY_W'(RES_VREF_15 - volt_reg);
                    res_phase_reg <= 1'b1;
                    state_reg     <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (res_phase_reg)
                        begin
                            x_reg     <= div_quo[ENTRY_W-1:0];
                            state_reg <= S_SCAN_GO;
                        end
                        else
                        begin
                            acc_reg    <= acc_reg + $signed(32'(div_quo));
                            region_reg <= REGION_INTERP;
                            state_reg  <= S_OUT;
                        end
                    end
                end
                S_SCAN_GO:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (hit && (cnt_reg == '0))
                    begin
                        acc_reg    <= 32'(first_deg_reg) * MILLI_S;
                        region_reg <= REGION_CLAMP_FIRST;
                        state_reg  <= S_OUT;
                    end
                    else if (hit)
                    begin
                        hi_reg    <= mem_q;
                        lo_reg    <= prev_reg;
                        state_reg <= S_INTERP;
                    end
                    else if (last_entry)
                    begin
                        acc_reg    <= 32'(last_deg_reg) * MILLI_S;
                        region_reg <= REGION_CLAMP_LAST;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        prev_reg <= mem_q;
                        cnt_reg  <= cnt_reg + IDX_W'(1);
                    end
                end
                S_INTERP:
                begin
                    if (falling)
                    begin
                        diff_reg <= hi_reg - x_reg;
                        den_reg  <= hi_reg - lo_reg;
                        deg_reg  <= 12'(first_deg_reg) - cnt_s;
                    end
                    else
                    begin
                        diff_reg <= lo_reg - x_reg;
                        den_reg  <= lo_reg - hi_reg;
                        deg_reg  <= 12'(first_deg_reg) + cnt_s - 12'sd1;
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    div_num_reg   <= 31'(diff_reg) * MILLI_U;
                    acc_reg       <= 32'(deg_reg) * MILLI_S;
                    res_phase_reg <= 1'b0;
                    state_reg     <= S_DIV_GO;
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.temp_milli <= sat[TEMP_W-1:0];
                        rsp_reg.region     <= region_reg;
                        rsp_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
